@@ rtl/mf2d_pkg.sv @@
`timescale 1ns / 1ps

package mf2d_pkg;

  // Default build options
  localparam int WindowDef    = 3;
  localparam int MaxWidthDef  = 1024;
  localparam int PixelBitsDef = 8;

  // Configuration registers
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 13;
  localparam int WidthBits   = 11;
  localparam int HeightBits  = 13;
  localparam int MaxHeight   = 4096;

  localparam logic [CfgIdxBits-1:0] IdxFrameWidth  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] IdxFrameHeight = CfgIdxBits'(1);

  localparam logic [WidthBits-1:0]  FrameWidthRst  = WidthBits'(640);
  localparam logic [HeightBits-1:0] FrameHeightRst = HeightBits'(480);

  // Per-word control carried down the filter pipeline
  typedef struct packed {
    logic vld;    // word produces an output pixel
    logic inner;  // full window inside the frame: take the median
    logic eof;    // last output pixel of the frame
  } ctl_t;

endpackage

@@ rtl/mf2d_if.sv @@
`timescale 1ns / 1ps

interface mf2d_in_if import mf2d_pkg::*; #(
  parameter int PIXEL_BITS = PixelBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;
  logic                  flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

interface mf2d_out_if import mf2d_pkg::*; #(
  parameter int PIXEL_BITS = PixelBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  end_of_frame;

  modport source (output valid, output pixel_out, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input end_of_frame, output ready);
endinterface

@@ rtl/median_filter_2d_unit.sv @@
`timescale 1ns / 1ps

// Streaming WINDOW x WINDOW median filter over one frame in raster order.
// Input channel pix_i: one word per pixel (pixel_in), or a flush word that
// only advances the stream to drain pending outputs once the frame is in.
// Output channel pix_o: one filtered pixel per word; end_of_frame marks the
// last pixel of the frame, after which the next input word opens a new one.
// Configuration: cfg_we_i writes frame_width (index 0) or frame_height
// (index 1); any write, also to an unused index, restarts the frame.
// Throughput: one word per clock while pix_o is not held off. The line
// buffer is a single RAM of (WINDOW-1) pixels per column, read and written
// back once per word.
// Latency: an output word follows the input word completing its window via
// the line buffer stage, window registers, sort stages and output register;
// in stream terms output p lags input p by WINDOW/2 rows plus WINDOW/2 pixels.
// Reset: counters clear and registers take 640 x 480; the line buffer has
// no reset, and no clearing pass is needed.
// Stall: when pix_o is held off, the pipeline keeps moving as long as the
// output register or the last sort stage is empty, then holds and drops pix_i.ready.

module median_filter_2d_unit import mf2d_pkg::*; #(
  parameter int WINDOW     = WindowDef,
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int PIXEL_BITS = PixelBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  mf2d_in_if.sink                pix_i,
  mf2d_out_if.source             pix_o
);

  localparam int H  = WINDOW / 2;
  localparam int N  = WINDOW * WINDOW;
  localparam int CW = $clog2(MAX_WIDTH);          // column / RAM address bits
  localparam int WW = $clog2(MAX_WIDTH + 1);      // effective width bits
  localparam int WX = WW + 1;
  localparam int FW = (WW > WidthBits) ? WW : WidthBits;
  localparam int RX = HeightBits + 1;
  localparam int DW = $clog2(H * MAX_WIDTH + H + 1);
  localparam int LW = (WINDOW - 1) * PIXEL_BITS;  // line buffer word

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [WidthBits-1:0]  frame_width_q;
  logic [HeightBits-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        IdxFrameWidth:  frame_width_q  <= cfg_data_i[WidthBits-1:0];
        IdxFrameHeight: frame_height_q <= cfg_data_i[HeightBits-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported range: zero acts as one, oversize as the maximum
  logic [FW-1:0]         fw_ext;
  logic [WW-1:0]         w_eff;
  logic [HeightBits-1:0] h_eff;
  logic [DW-1:0]         delay;

  always_comb begin
    fw_ext = FW'(frame_width_q);
    if (fw_ext == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > FW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext[WW-1:0];
    end
    if (frame_height_q == '0) begin
      h_eff = HeightBits'(1);
    end else if (frame_height_q > HeightBits'(MaxHeight)) begin
      h_eff = HeightBits'(MaxHeight);
    end else begin
      h_eff = frame_height_q;
    end
    // words from frame start until the first output
    delay = DW'(H) * DW'(w_eff) + DW'(H);
  end

  // ---------------------------------------------------------------------
  // Stream position (accept stage)
  // ---------------------------------------------------------------------
  logic                  en;
  logic                  acc;
  ctl_t                  sort_ctl;
  logic                  out_vld_q;

  logic [CW-1:0]         in_col_q, in_col_d;
  logic [HeightBits-1:0] in_row_q, in_row_d;
  logic                  drain_q, drain_d;
  logic [DW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         out_col_q, out_col_d;
  logic [HeightBits-1:0] out_row_q, out_row_d;

  logic s0_act, out_on, s0_eof, s0_inner, in_wrap, out_wrap;

  // advance the whole pipeline unless a finished word would be overrun
  assign en  = !out_vld_q || pix_o.ready || !sort_ctl.vld;
  assign acc = pix_i.valid && en;

  always_comb begin
    // a flush before the last pixel is dropped: no effect at all
    s0_act   = drain_q || !pix_i.flush;
    out_on   = (cnt_q == delay);
    in_wrap  = (WW'(in_col_q) == w_eff - WW'(1));
    out_wrap = (WW'(out_col_q) == w_eff - WW'(1));
    s0_eof   = out_on && out_wrap && (out_row_q == h_eff - HeightBits'(1));
    s0_inner = out_on &&
               (RX'(out_row_q) >= RX'(H)) &&
               (RX'(out_row_q) + RX'(H) < RX'(h_eff)) &&
               (WX'(out_col_q) >= WX'(H)) &&
               (WX'(out_col_q) + WX'(H) < WX'(w_eff));

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    drain_d   = drain_q;
    cnt_d     = cnt_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;

    if (cfg_we_i || (acc && s0_act && s0_eof)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      drain_d   = 1'b0;
      cnt_d     = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (acc && s0_act) begin
      if (out_on) begin
        if (out_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + HeightBits'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end else begin
        cnt_d = cnt_q + DW'(1);
      end
      if (in_wrap) begin
        in_col_d = '0;
        if (!drain_q) begin
          in_row_d = in_row_q + HeightBits'(1);
          // last pixel of the frame is in: switch to drain
          if (in_row_q == h_eff - HeightBits'(1)) begin
            drain_d = 1'b1;
          end
        end
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      drain_q   <= 1'b0;
      cnt_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      drain_q   <= drain_d;
      cnt_q     <= cnt_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Line buffer: read column at accept, write it back one stage later
  // ---------------------------------------------------------------------
  logic                               s1_act_q;
  ctl_t                               s1_ctl_q;
  logic [CW-1:0]                      s1_col_q;
  logic [PIXEL_BITS-1:0]              s1_pix_q;
  logic                               re, we, fwd_d, fwd_q;
  logic [WINDOW-2:0][PIXEL_BITS-1:0]  rdata, rd_sel, wdata, fwd_dat_q;
  logic [WINDOW-1:0][PIXEL_BITS-1:0]  stack;

  assign re = acc && s0_act;
  assign we = en && s1_act_q;
  // back-to-back words on one column: the RAM still returns the old word
  assign fwd_d = re && we && (in_col_q == s1_col_q);

  mf2d_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_col_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (in_col_q),
    .rdata_o (rdata)
  );

  always_comb begin
    rd_sel = fwd_q ? fwd_dat_q : rdata;
    // slot 0 is the row just above; shift down, newest pixel in slot 0
    wdata[0] = s1_pix_q;
    for (int k = 1; k < WINDOW - 1; k++) begin
      wdata[k] = rd_sel[k-1];
    end
    // window column, top row first
    stack[WINDOW-1] = s1_pix_q;
    for (int i = 0; i < WINDOW - 1; i++) begin
      stack[i] = rd_sel[WINDOW-2-i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_col_q  <= in_col_q;
      s1_pix_q  <= pix_i.pixel_in;
      fwd_dat_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_act_q <= 1'b0;
      s1_ctl_q <= '0;
      fwd_q    <= 1'b0;
    end else if (en) begin
      s1_act_q       <= acc && s0_act;
      s1_ctl_q.vld   <= acc && s0_act && out_on;
      s1_ctl_q.inner <= s0_inner;
      s1_ctl_q.eof   <= s0_eof;
      fwd_q          <= fwd_d;
    end
  end

  // ---------------------------------------------------------------------
  // Window registers: shift one column in per active word
  // ---------------------------------------------------------------------
  logic [WINDOW-1:0][WINDOW-1:0][PIXEL_BITS-1:0] win_q;
  logic [N-1:0][PIXEL_BITS-1:0]                  win_flat;
  ctl_t                                          s2_ctl_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      for (int i = 0; i < WINDOW; i++) begin
        for (int j = 0; j < WINDOW - 1; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
        win_q[i][WINDOW-1] <= stack[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (en) begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        win_flat[i*WINDOW+j] = win_q[i][j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Median network; the window center rides along for border pixels
  // ---------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] med, ctr;

  mf2d_sort #(
    .WINDOW     (WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_sort (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .win_i  (win_flat),
    .ctr_i  (win_q[H][H]),
    .ctl_i  (s2_ctl_q),
    .med_o  (med),
    .ctr_o  (ctr),
    .ctl_o  (sort_ctl)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || pix_o.ready) begin
      out_vld_q <= sort_ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pix_o.ready) begin
      out_pix_q <= sort_ctl.inner ? med : ctr;
      out_eof_q <= sort_ctl.eof;
    end
  end

  assign pix_i.ready        = en;
  assign pix_o.valid        = out_vld_q;
  assign pix_o.pixel_out    = out_pix_q;
  assign pix_o.end_of_frame = out_eof_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !pix_o.valid |-> pix_i.ready
  ) else $error("input held off with an empty output register");

  a_inner_not_in_drain: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (acc && s0_act && s0_inner) |-> !drain_q
  ) else $error("median window reaches past the last pixel");

  a_eof_restarts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (acc && s0_act && s0_eof) |=> (cnt_q == '0 && out_col_q == '0 && !drain_q)
  ) else $error("frame end did not restart the stream position");

  a_fwd_same_column: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fwd_d |-> (w_eff == WW'(1) || in_col_q == '0)
  ) else $error("line buffer column repeated in mid row");

endmodule

@@ rtl/mf2d_ram.sv @@
`timescale 1ns / 1ps

module mf2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mf2d_sort.sv @@
`timescale 1ns / 1ps

module mf2d_sort import mf2d_pkg::*; #(
  parameter int WINDOW     = WindowDef,
  parameter int PIXEL_BITS = PixelBitsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic [WINDOW*WINDOW-1:0][PIXEL_BITS-1:0]    win_i,
  input  logic [PIXEL_BITS-1:0]                       ctr_i,
  input  ctl_t                                        ctl_i,
  output logic [PIXEL_BITS-1:0]                       med_o,
  output logic [PIXEL_BITS-1:0]                       ctr_o,
  output ctl_t                                        ctl_o
);

  localparam int N    = WINDOW * WINDOW;
  localparam int NStg = (N + 1) / 2;

  typedef logic [N-1:0][PIXEL_BITS-1:0] vec_t;

  // one even and one odd pass of an odd-even transposition network
  function automatic vec_t two_pass(input vec_t v);
    vec_t                  r;
    logic [PIXEL_BITS-1:0] t;
    r = v;
    for (int i = 0; i + 1 < N; i += 2) begin
      if (r[i] > r[i+1]) begin
        t      = r[i];
        r[i]   = r[i+1];
        r[i+1] = t;
      end
    end
    for (int i = 1; i + 1 < N; i += 2) begin
      if (r[i] > r[i+1]) begin
        t      = r[i];
        r[i]   = r[i+1];
        r[i+1] = t;
      end
    end
    return r;
  endfunction

  vec_t                  stg_q [NStg];
  vec_t                  nxt   [NStg];
  logic [PIXEL_BITS-1:0] ctr_q [NStg];
  ctl_t                  ctl_q [NStg];

  always_comb begin
    nxt[0] = two_pass(win_i);
    for (int k = 1; k < NStg; k++) begin
      nxt[k] = two_pass(stg_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NStg; k++) begin
        stg_q[k] <= nxt[k];
      end
      ctr_q[0] <= ctr_i;
      for (int k = 1; k < NStg; k++) begin
        ctr_q[k] <= ctr_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStg; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < NStg; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  assign med_o = stg_q[NStg-1][N/2];
  assign ctr_o = ctr_q[NStg-1];
  assign ctl_o = ctl_q[NStg-1];

endmodule

@@ bench/tb_median_filter_2d_unit.sv @@
`timescale 1ns / 1ps

module tb_median_filter_2d_unit import mf2d_pkg::*;;

  // Window geometry of the build under test
  localparam int Win        = WindowDef;
  localparam int HalfWin    = Win / 2;
  localparam int WinArea    = Win * Win;
  localparam int HistDepth  = (Win - 1) * MaxWidthDef + Win;
  localparam int PixBits    = PixelBitsDef;

  // Indexes past the register list: a write there only restarts the frame
  localparam logic [CfgIdxBits-1:0] IdxSpareLo = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] IdxSpareHi = CfgIdxBits'(3);

  // The last output word trails the last input word through the pipeline;
  // a word that makes no output may still be in flight when the queue runs dry.
  localparam int SettleCycles = 16;
  localparam int LongHold     = 400;
  localparam int RandWords    = 320;
  localparam int TallWords    = 160;
  localparam int WideTail     = 32;
  localparam int MaxReports   = 10;

  // Slowest honest run: ~1.7k words, sent in bursts behind random gaps to a
  // sink that may stall most cycles, plus a few dozen settle pauses and one
  // long hold. CycleLimit sits far above what that run needs.
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [PixBits-1:0] pixel;
    logic               eof;
  } px_word_t;

  typedef enum logic {StepCfgWrite, StepWord} step_kind_e;
  typedef enum logic [1:0] {ChkModel, ChkNone, ChkTyped} row_chk_e;
  typedef enum logic [1:0] {SinkOpen, SinkCoin, SinkSparse, SinkComb} sink_mode_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
    logic [PixBits-1:0]     pix;
    logic                   flush;
    row_chk_e               chk;
    px_word_t               want;
  } dir_row_t;

  // Directed opening. A 1x1 frame (written as 0 x 0, which acts as 1 x 1) has
  // a lag of two words: a flush before the pixel is dropped, the pixel that
  // arrives during the drain is discarded, and the third word returns the
  // pixel with end_of_frame. Then a spare-index write and a 3x3 frame whose
  // center is the median of four zeros, one 0x80 and four 0xFF.
  localparam int NumDirRows = 25;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{StepCfgWrite, IdxFrameWidth,  13'd0,     8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepCfgWrite, IdxFrameHeight, 13'd0,     8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'hFF, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkTyped, '{8'hFF, 1'b1}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'hA5, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkTyped, '{8'hA5, 1'b1}},
    '{StepCfgWrite, IdxSpareLo,     13'h1FFF,  8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepCfgWrite, IdxFrameWidth,  13'd3,     8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepCfgWrite, IdxFrameHeight, 13'd3,     8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'hFF, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'hFF, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b0, ChkNone,  '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h80, 1'b0, ChkTyped, '{8'hFF, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b0, ChkTyped, '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'hFF, 1'b0, ChkTyped, '{8'hFF, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'hFF, 1'b0, ChkTyped, '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b0, ChkTyped, '{8'h80, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkTyped, '{8'h00, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkTyped, '{8'hFF, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkTyped, '{8'hFF, 1'b0}},
    '{StepWord,     IdxFrameWidth,  13'd0,     8'h00, 1'b1, ChkTyped, '{8'h00, 1'b1}}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  mf2d_in_if  #(.PIXEL_BITS(PixBits)) pix_in_bus ();
  mf2d_out_if #(.PIXEL_BITS(PixBits)) pix_out_bus ();

  median_filter_2d_unit #(
    .WINDOW    (Win),
    .MAX_WIDTH (MaxWidthDef),
    .PIXEL_BITS(PixBits)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix_in_bus),
    .pix_o     (pix_out_bus)
  );

  // Shadow of the filter: registers, stream position and past pixels
  logic [WidthBits-1:0]  width_reg  = FrameWidthRst;
  logic [HeightBits-1:0] height_reg = FrameHeightRst;
  int unsigned           col_q = 0;
  int unsigned           row_q = 0;
  logic [PixBits-1:0]    pix_hist [HistDepth];

  px_word_t    pending_px [$];
  px_word_t    head_px;
  int unsigned bad_words = 0;
  int unsigned words_sent = 0;
  int unsigned cyc_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_len;
  bit          hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a hung handshake or a lost word ends here
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Out-of-range sizes clamp: zero acts as one, too large acts as the maximum
  function automatic int unsigned frame_cols();
    if (width_reg == '0) return 1;
    if (width_reg > MaxWidthDef) return MaxWidthDef;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned frame_rows();
    if (height_reg == '0) return 1;
    if (height_reg > MaxHeight) return MaxHeight;
    return 32'(height_reg);
  endfunction

  // Median by rank: the value with at most half the window strictly below it
  // and more than half at or below it.
  function automatic logic [PixBits-1:0] window_median(
      input logic [WinArea-1:0][PixBits-1:0] win);
    int unsigned below, upto;
    for (int k = 0; k < WinArea; k++) begin
      below = 0;
      upto  = 0;
      for (int m = 0; m < WinArea; m++) begin
        if (win[m] < win[k]) below++;
        if (win[m] <= win[k]) upto++;
      end
      if (below <= WinArea / 2 && upto > WinArea / 2) return win[k];
    end
    return '0;
  endfunction

  // Advance the shadow by one accepted word; report the output word it causes
  task automatic filter_step(input logic [PixBits-1:0] pix, input logic is_flush,
                             output bit got, output px_word_t word);
    int unsigned w, h, total, lag, pos, p, r, c;
    logic [WinArea-1:0][PixBits-1:0] win;
    got   = 1'b0;
    word  = '0;
    w     = frame_cols();
    h     = frame_rows();
    total = w * h;
    lag   = HalfWin * w + HalfWin;
    pos   = row_q * w + col_q;
    if (pos < total) begin
      // drop a flush while the frame is still arriving
      if (is_flush) return;
      pix_hist[pos % HistDepth] = pix;
    end
    if (pos >= lag) begin
      p = pos - lag;
      r = p / w;
      c = p % w;
      word.eof = (p >= total - 1);
      if (r >= HalfWin && r + HalfWin < h && c >= HalfWin && c + HalfWin < w) begin
        for (int i = 0; i < Win; i++)
          for (int j = 0; j < Win; j++)
            win[i * Win + j] = pix_hist[(p - lag + i * w + j) % HistDepth];
        word.pixel = window_median(win);
      end else begin
        word.pixel = pix_hist[p % HistDepth];
      end
      got = 1'b1;
      if (word.eof) begin
        col_q = 0;
        row_q = 0;
        return;
      end
    end
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
  endtask

  // Offer one word, hold it until accepted, then record what it should produce
  task automatic send_word(input logic [PixBits-1:0] pix, input logic is_flush,
                           input row_chk_e chk, input px_word_t typed);
    bit       got;
    px_word_t word;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap_len = $urandom_range(1, 6);
      pix_in_bus.valid <= 1'b0;
      repeat (gap_len) @(posedge clk_i);
    end
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.pixel_in <= pix;
    pix_in_bus.flush    <= is_flush;
    do @(posedge clk_i); while (!(pix_in_bus.valid && pix_in_bus.ready));
    burst_left--;
    filter_step(pix, is_flush, got, word);
    case (chk)
      ChkModel: if (got) pending_px.push_back(word);
      ChkTyped: pending_px.push_back(typed);
      default: ;
    endcase
  endtask

  // Write a register only once the block has gone quiet
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    pix_in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      IdxFrameWidth:  width_reg  = data[WidthBits-1:0];
      IdxFrameHeight: height_reg = data[HeightBits-1:0];
      default: ;
    endcase
    // any write restarts the frame
    col_q = 0;
    row_q = 0;
  endtask

  function automatic logic [PixBits-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PixBits'($urandom_range(0, (1 << PixBits) - 1));
    endcase
  endfunction

  // Walk n_items stream positions from the start of a frame. Pixels may be
  // preceded by a stray flush (dropped); past the last pixel, drain mostly
  // with flush words and sometimes with pixels that get discarded.
  task automatic run_frame(input int unsigned n_items);
    int unsigned total;
    total = frame_cols() * frame_rows();
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k < total) begin
        if ($urandom_range(0, 15) == 0) send_word(rand_pixel(), 1'b1, ChkModel, '0);
        send_word(rand_pixel(), 1'b0, ChkModel, '0);
      end else begin
        send_word(rand_pixel(), $urandom_range(0, 3) != 0, ChkModel, '0);
      end
      words_sent++;
    end
  endtask

  task automatic note_mismatch(input string field, input int unsigned want_v,
                               input int unsigned got_v);
    bad_words++;
    if (bad_words <= MaxReports)
      $display("mismatch @%0d: %s expected %0h got %0h", cyc_count, field, want_v, got_v);
  endtask

  // Compare every accepted output word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pix_out_bus.valid && pix_out_bus.ready) begin
      if (pending_px.size() == 0) begin
        note_mismatch("unexpected word, pixel_out", 0, pix_out_bus.pixel_out);
      end else begin
        head_px = pending_px.pop_front();
        if (pix_out_bus.pixel_out !== head_px.pixel)
          note_mismatch("pixel_out", head_px.pixel, pix_out_bus.pixel_out);
        if (pix_out_bus.end_of_frame !== head_px.eof)
          note_mismatch("end_of_frame", head_px.eof, pix_out_bus.end_of_frame);
      end
    end
  end

  // Sink: switch between stall patterns at random, and hold off for a long
  // stretch once when asked, so the block backs up and drops its input ready.
  initial begin
    sink_mode_e  mode;
    int unsigned mode_left;
    mode      = SinkOpen;
    mode_left = 0;
    pix_out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pix_out_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        SinkOpen:   pix_out_bus.ready <= 1'b1;
        SinkCoin:   pix_out_bus.ready <= $urandom_range(0, 1);
        SinkSparse: pix_out_bus.ready <= ($urandom_range(0, 7) == 0);
        default:    pix_out_bus.ready <= ((cyc_count % 7) < 3);
      endcase
    end
  end

  // Stimulus: directed table, two cut frames at the size extremes, random frames
  initial begin
    int unsigned rand_goal, full;
    bit          restart_due, wrote;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= IdxFrameWidth;
    cfg_data_i          <= '0;
    pix_in_bus.valid    <= 1'b0;
    pix_in_bus.pixel_in <= '0;
    pix_in_bus.flush    <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    for (int n = 0; n < NumDirRows; n++) begin
      if (DirRows[n].kind == StepCfgWrite)
        write_reg(DirRows[n].idx, DirRows[n].data);
      else
        send_word(DirRows[n].pix, DirRows[n].flush, DirRows[n].chk, DirRows[n].want);
    end

    // One column, height past the maximum: all border, a lag of two words.
    // Hold the sink off meanwhile so the block fills up and stalls its input;
    // the next write cuts the frame short.
    write_reg(IdxFrameWidth, 13'd1);
    write_reg(IdxFrameHeight, 13'h1FFF);
    hold_req = 1'b1;
    run_frame(TallWords);

    // Width past the maximum acts as the full line buffer: run just past the
    // lag of one full row so the first border pixels come out, then cut.
    write_reg(IdxFrameWidth, 13'h1FFF);
    write_reg(IdxFrameHeight, 13'd3);
    run_frame(HalfWin * frame_cols() + HalfWin + WideTail);

    // Random frames of mostly small sizes; about one in ten is cut short and
    // restarted by a register write.
    rand_goal   = words_sent + RandWords;
    restart_due = 1'b1;
    while (words_sent < rand_goal) begin
      wrote = 1'b0;
      if (restart_due || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0:       write_reg(IdxFrameWidth, '0);
          1, 2:    write_reg(IdxFrameWidth, CfgDataBits'($urandom_range(11, 48)));
          default: write_reg(IdxFrameWidth, CfgDataBits'($urandom_range(1, 10)));
        endcase
        wrote = 1'b1;
      end
      if (restart_due || $urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 15) == 0) write_reg(IdxFrameHeight, '0);
        else write_reg(IdxFrameHeight, CfgDataBits'($urandom_range(1, 7)));
        wrote = 1'b1;
      end
      if ((restart_due && !wrote) || $urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? IdxSpareHi : IdxSpareLo,
                  CfgDataBits'($urandom));
      full = frame_cols() * frame_rows() + HalfWin * frame_cols() + HalfWin;
      if ($urandom_range(0, 9) == 0) begin
        run_frame($urandom_range(1, full - 1));
        restart_due = 1'b1;
      end else begin
        run_frame(full);
        restart_due = 1'b0;
      end
    end

    // Wait out the last expected word, then watch for strays
    pix_in_bus.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (bad_words == 0 && pending_px.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
